@@ design/miu_pkg.sv @@
// ----------------------------------------------------------------------------
// miu_pkg: shared types and constants for the integer execute unit
// Operation codes, status codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package miu_pkg;

    localparam int unsigned DataW   = 32;
    localparam int unsigned CmdW    = 6;
    localparam int unsigned ImmW    = 16;
    localparam int unsigned ShW     = 5;
    localparam int unsigned StW     = 2;
    localparam int unsigned CntW    = 6;

    typedef enum logic [CmdW-1:0] {
        OP_ADD = 6'd0, OP_ADDU = 6'd1, OP_ADDI = 6'd2, OP_ADDIU = 6'd3,
        OP_SUB = 6'd4, OP_SUBU = 6'd5, OP_AND = 6'd6, OP_ANDI = 6'd7,
        OP_OR = 6'd8, OP_ORI = 6'd9, OP_XOR = 6'd10, OP_XORI = 6'd11,
        OP_NOR = 6'd12, OP_LUI = 6'd13, OP_SLL = 6'd14, OP_SRL = 6'd15,
        OP_SRA = 6'd16, OP_SLLV = 6'd17, OP_SRLV = 6'd18, OP_SRAV = 6'd19,
        OP_SLT = 6'd20, OP_SLTU = 6'd21, OP_SLTI = 6'd22, OP_SLTIU = 6'd23,
        OP_MULT = 6'd24, OP_MULTU = 6'd25, OP_DIV = 6'd26, OP_DIVU = 6'd27,
        OP_MFHI = 6'd28, OP_MFLO = 6'd29, OP_MTHI = 6'd30, OP_MTLO = 6'd31,
        OP_TEQ = 6'd32, OP_TNE = 6'd33, OP_TGE = 6'd34, OP_TGEU = 6'd35,
        OP_TLT = 6'd36, OP_TLTU = 6'd37, OP_TEQI = 6'd38, OP_TNEI = 6'd39,
        OP_TGEI = 6'd40, OP_TGEIU = 6'd41, OP_TLTI = 6'd42, OP_TLTIU = 6'd43
    } t_op;

    localparam logic [StW-1:0] ST_OK   = 2'd0;
    localparam logic [StW-1:0] ST_OVF  = 2'd1;
    localparam logic [StW-1:0] ST_DIVE = 2'd2;
    localparam logic [StW-1:0] ST_TRAP = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the input beat and form the direct result
        logic mul_step;  // one 16x32 partial product
        logic div_step;  // one restoring division bit
        logic finish;    // write HI/LO from the long operation unless a divide error was flagged
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
    } t_dp_stat;

endpackage

@@ design/miu_if.sv @@
// ----------------------------------------------------------------------------
// miu_in_if / miu_out_if: valid/ready channels of the execute unit
// Input carries one instruction, output carries one result beat.
// ----------------------------------------------------------------------------
interface miu_in_if;
    import miu_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CmdW-1:0]           cmd;
    logic signed [DataW-1:0]   a_value;
    logic signed [DataW-1:0]   b_value;
    logic signed [ImmW-1:0]    imm;
    logic [ShW-1:0]            shamt;
    modport source (output valid, cmd, a_value, b_value, imm, shamt, input ready);
    modport sink   (input valid, cmd, a_value, b_value, imm, shamt, output ready);
endinterface

interface miu_out_if;
    import miu_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [DataW-1:0]   result;
    logic                      write_result;
    logic [StW-1:0]            status;
    modport source (output valid, result, write_result, status, input ready);
    modport sink   (input valid, result, write_result, status, output ready);
endinterface

@@ design/mips_integer_execute_unit.sv @@
// ----------------------------------------------------------------------------
// mips_integer_execute_unit: MIPS32 integer execute unit with HI/LO
// One instruction beat in, one result beat out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries cmd, a_value (rs), b_value (rt), imm and shamt. A beat is
//          taken when valid and ready are high at a rising edge.
//   out_ch carries result, write_result and status, one beat per input beat.
// Sequence: ALU, shift, compare, trap and HI/LO move ops present their registered
//   result in the cycle after acceptance. MULT/MULTU run two 16x32 partial
//   products on one multiplier, then the HI/LO write; DIV/DIVU produce one
//   restoring quotient bit per cycle, then the sign fix-up and HI/LO write.
// Throughput: one item per cycle for ALU, shift, compare, trap and HI/LO move ops
//   while out_ch drains; a new beat is accepted in the same cycle the held result is taken.
// Stall: a held result beat stays stable on out_ch until ready is high; in_ch
//   is not ready meanwhile.
// Reset: i_rst_n low (synchronous) clears HI, LO and the sequencer; no
//   result beat is pending afterwards.
// ----------------------------------------------------------------------------
module mips_integer_execute_unit
    import miu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    miu_in_if.sink    in_ch,
    miu_out_if.source out_ch
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: owns the handshake and the step count
    miu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // datapath: operands, ALU, HI/LO and the shared multiply/divide unit
    miu_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_op     (in_ch.cmd),
        .i_a      (in_ch.a_value),
        .i_b      (in_ch.b_value),
        .i_imm    (in_ch.imm),
        .i_shamt  (in_ch.shamt),
        .o_stat   (dp_stat),
        .o_result (out_ch.result),
        .o_write  (out_ch.write_result),
        .o_status (out_ch.status)
    );

endmodule

@@ design/miu_datapath.sv @@
// ----------------------------------------------------------------------------
// miu_datapath: operand registers, ALU, HI/LO, shared multiply/divide unit
// Multiply runs two 16x32 partial products; divide is restoring, 1 bit/cycle.
// ----------------------------------------------------------------------------
module miu_datapath
    import miu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [CmdW-1:0]       i_op,
    input  logic [DataW-1:0]      i_a,
    input  logic [DataW-1:0]      i_b,
    input  logic [ImmW-1:0]       i_imm,
    input  logic [ShW-1:0]        i_shamt,
    output t_dp_stat              o_stat,
    output logic [DataW-1:0]      o_result,
    output logic                  o_write,
    output logic [StW-1:0]        o_status
);

    logic [DataW-1:0]   r_hi, r_lo, n_hi, n_lo;
    logic [DataW-1:0]   r_res, n_res;
    logic               r_wr, n_wr;
    logic [StW-1:0]     r_st, n_st;
    // long operation state
    logic [CmdW-1:0]    r_op;
    logic               r_neg_q, r_neg_r, r_err;
    logic [DataW-1:0]   r_div;           // divisor magnitude / multiplicand
    logic [DataW-1:0]   r_quo;           // dividend shifting into quotient
    logic [DataW:0]     r_rem;           // partial remainder
    logic [2*DataW-1:0] r_acc;           // product accumulator
    logic               r_half;          // which 16-bit half of multiplier

    logic [DataW-1:0]   simm, zimm, sh_in;
    logic [ShW-1:0]     sh;
    logic [DataW:0]     sum;
    logic               slt_ab, sltu_ab, slt_ai, sltu_ai, trap;
    logic               div_err;
    logic [DataW-1:0]   a_mag, b_mag;
    logic [DataW:0]     rem_sh, rem_sub;
    logic [2*DataW-1:0] pp, prod, q_fix, r_fix;
    logic [ImmW:0]      mpart;

    always_comb begin
        simm    = {{(DataW-ImmW){i_imm[ImmW-1]}}, i_imm};
        zimm    = {{(DataW-ImmW){1'b0}}, i_imm};
        slt_ab  = $signed(i_a) < $signed(i_b);
        sltu_ab = i_a < i_b;
        slt_ai  = $signed(i_a) < $signed(simm);
        sltu_ai = i_a < simm;
        sh_in   = i_b;
        sh      = (i_op == OP_SLL || i_op == OP_SRL || i_op == OP_SRA) ? i_shamt
                                                                      : i_a[ShW-1:0];
        a_mag   = (i_a[DataW-1] && i_op == OP_DIV) ? (~i_a + 1'b1) : i_a;
        b_mag   = (i_b[DataW-1] && i_op == OP_DIV) ? (~i_b + 1'b1) : i_b;
        // zero divisor, or the one signed quotient that does not fit
        div_err = (i_b == '0) ||
                  (i_op == OP_DIV && i_a == {1'b1, {(DataW-1){1'b0}}} && i_b == '1);
        o_stat.is_mul = (i_op == OP_MULT || i_op == OP_MULTU);
        o_stat.is_div = (i_op == OP_DIV || i_op == OP_DIVU);
    end

    // result of the direct ops, captured at load
    always_comb begin
        n_res = '0;
        n_wr  = 1'b1;
        n_st  = ST_OK;
        trap  = 1'b0;
        sum   = '0;
        unique case (i_op)
            OP_ADD, OP_ADDI, OP_SUB: begin
                if (i_op == OP_SUB) sum = {i_a[DataW-1], i_a} - {i_b[DataW-1], i_b};
                else if (i_op == OP_ADD) sum = {i_a[DataW-1], i_a} + {i_b[DataW-1], i_b};
                else sum = {i_a[DataW-1], i_a} + {simm[DataW-1], simm};
                if (sum[DataW] != sum[DataW-1]) begin
                    n_st = ST_OVF;
                    n_wr = 1'b0;
                end else begin
                    n_res = sum[DataW-1:0];
                end
            end
            OP_ADDU:  n_res = i_a + i_b;
            OP_ADDIU: n_res = i_a + simm;
            OP_SUBU:  n_res = i_a - i_b;
            OP_AND:   n_res = i_a & i_b;
            OP_ANDI:  n_res = i_a & zimm;
            OP_OR:    n_res = i_a | i_b;
            OP_ORI:   n_res = i_a | zimm;
            OP_XOR:   n_res = i_a ^ i_b;
            OP_XORI:  n_res = i_a ^ zimm;
            OP_NOR:   n_res = ~(i_a | i_b);
            OP_LUI:   n_res = {i_imm, {ImmW{1'b0}}};
            OP_SLL, OP_SLLV: n_res = sh_in << sh;
            OP_SRL, OP_SRLV: n_res = sh_in >> sh;
            OP_SRA, OP_SRAV: n_res = DataW'($signed(sh_in) >>> sh);
            OP_SLT:   n_res = {{(DataW-1){1'b0}}, slt_ab};
            OP_SLTU:  n_res = {{(DataW-1){1'b0}}, sltu_ab};
            OP_SLTI:  n_res = {{(DataW-1){1'b0}}, slt_ai};
            OP_SLTIU: n_res = {{(DataW-1){1'b0}}, sltu_ai};
            OP_MFHI:  n_res = r_hi;
            OP_MFLO:  n_res = r_lo;
            OP_MULT, OP_MULTU, OP_MTHI, OP_MTLO: n_wr = 1'b0;
            OP_DIV, OP_DIVU: begin
                n_wr = 1'b0;
                if (div_err) n_st = ST_DIVE;
            end
            OP_TEQ:   begin n_wr = 1'b0; trap = (i_a == i_b);  end
            OP_TNE:   begin n_wr = 1'b0; trap = (i_a != i_b);  end
            OP_TGE:   begin n_wr = 1'b0; trap = !slt_ab;       end
            OP_TGEU:  begin n_wr = 1'b0; trap = !sltu_ab;      end
            OP_TLT:   begin n_wr = 1'b0; trap = slt_ab;        end
            OP_TLTU:  begin n_wr = 1'b0; trap = sltu_ab;       end
            OP_TEQI:  begin n_wr = 1'b0; trap = (i_a == simm); end
            OP_TNEI:  begin n_wr = 1'b0; trap = (i_a != simm); end
            OP_TGEI:  begin n_wr = 1'b0; trap = !slt_ai;       end
            OP_TGEIU: begin n_wr = 1'b0; trap = !sltu_ai;      end
            OP_TLTI:  begin n_wr = 1'b0; trap = slt_ai;        end
            OP_TLTIU: begin n_wr = 1'b0; trap = sltu_ai;       end
            default:  n_wr = 1'b0;
        endcase
        if (trap) n_st = ST_TRAP;
    end

    // shared long-operation arithmetic and HI/LO update
    always_comb begin
        rem_sh  = {r_rem[DataW-1:0], r_quo[DataW-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        // multiplier half, sign-extended for MULT high half
        mpart   = r_half ? {(r_op == OP_MULT) & r_rem[DataW-1], r_rem[DataW-1:ImmW]}
                         : {1'b0, r_rem[ImmW-1:0]};
        pp      = 64'($signed({(r_op == OP_MULT) & r_div[DataW-1], r_div})
                      * $signed(mpart));
        prod    = r_acc;
        q_fix   = r_neg_q ? (~{32'd0, r_quo} + 1'b1) : {32'd0, r_quo};
        r_fix   = r_neg_r ? (~{32'd0, r_rem[DataW-1:0]} + 1'b1)
                          : {32'd0, r_rem[DataW-1:0]};
        n_hi = r_hi;
        n_lo = r_lo;
        if (i_cmd.load && i_op == OP_MTHI) n_hi = i_a;
        if (i_cmd.load && i_op == OP_MTLO) n_lo = i_a;
        if (i_cmd.finish && !r_err) begin
            if (r_op == OP_MULT || r_op == OP_MULTU) begin
                n_hi = prod[2*DataW-1:DataW];
                n_lo = prod[DataW-1:0];
            end else begin
                n_hi = r_fix[DataW-1:0];
                n_lo = q_fix[DataW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi <= '0;
            r_lo <= '0;
        end else begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res  <= n_res;
            r_wr   <= n_wr;
            r_st   <= n_st;
            r_op   <= i_op;
            r_half <= 1'b0;
            r_acc  <= '0;
            if (o_stat.is_mul) begin
                r_div <= i_a;
                r_rem <= {1'b0, i_b};
                r_neg_q <= 1'b0;
                r_neg_r <= 1'b0;
                r_err <= 1'b0;
            end else begin
                r_div   <= b_mag;
                r_quo   <= a_mag;
                r_rem   <= '0;
                r_neg_q <= (i_op == OP_DIV) && (i_a[DataW-1] ^ i_b[DataW-1]);
                r_neg_r <= (i_op == OP_DIV) && i_a[DataW-1];
                r_err   <= div_err;
            end
        end else if (i_cmd.mul_step) begin
            r_acc  <= r_half ? (r_acc + (pp << ImmW)) : (r_acc + pp);
            r_half <= 1'b1;
        end else if (i_cmd.div_step) begin
            if (!rem_sub[DataW]) begin
                r_rem <= rem_sub;
                r_quo <= {r_quo[DataW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[DataW-2:0], 1'b0};
            end
        end
    end

    assign o_result = r_res;
    assign o_write  = r_wr;
    assign o_status = r_st;

endmodule

@@ design/miu_ctrl.sv @@
// ----------------------------------------------------------------------------
// miu_ctrl: sequencer for the execute unit
// Accepts a beat, runs multiply/divide steps, then holds the result beat.
// ----------------------------------------------------------------------------
module miu_ctrl
    import miu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            acc;

    always_comb begin
        o_in_ready  = (r_state == S_IDLE) || (r_state == S_OUT && i_out_ready);
        o_out_valid = (r_state == S_OUT);
        acc         = i_in_valid && o_in_ready;
        o_cmd       = '0;
        o_cmd.load  = acc;
        n_state     = r_state;
        n_cnt       = r_cnt;
        unique case (r_state)
            S_IDLE, S_OUT: begin
                if (r_state == S_OUT && i_out_ready) n_state = S_IDLE;
                if (acc) begin
                    n_cnt = '0;
                    if (i_stat.is_mul)      n_state = S_MUL;
                    else if (i_stat.is_div) n_state = S_DIV;
                    else                    n_state = S_OUT;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[0]) n_state = S_FIN;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CntW'(DataW - 1)) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
